/* rtl/core/rv32cd_pkg.sv */
package rv32cd_pkg;

   localparam int HalfwordWidth = 16;
   localparam int OperationWidth = 5;
   localparam int FormatWidth = 4;
   localparam int RegWidth = 5;
   localparam int ImmWidth = 18;

   typedef logic [HalfwordWidth-1:0]  halfword_type;
   typedef logic [OperationWidth-1:0] operation_type;
   typedef logic [FormatWidth-1:0]    format_type;
   typedef logic [RegWidth-1:0]       reg_num_type;
   typedef logic signed [ImmWidth-1:0] imm_type;

   typedef struct packed {
      operation_type operation;
      format_type    format;
   } class_type;

   localparam operation_type OP_ILLEGAL  = 5'd0;
   localparam operation_type OP_ADDI4SPN = 5'd1;
   localparam operation_type OP_LW       = 5'd2;
   localparam operation_type OP_SW       = 5'd3;
   localparam operation_type OP_NOP      = 5'd4;
   localparam operation_type OP_ADDI     = 5'd5;
   localparam operation_type OP_JAL      = 5'd6;
   localparam operation_type OP_LI       = 5'd7;
   localparam operation_type OP_ADDI16SP = 5'd8;
   localparam operation_type OP_LUI      = 5'd9;
   localparam operation_type OP_SRLI     = 5'd10;
   localparam operation_type OP_SRAI     = 5'd11;
   localparam operation_type OP_ANDI     = 5'd12;
   localparam operation_type OP_SUB      = 5'd13;
   localparam operation_type OP_XOR      = 5'd14;
   localparam operation_type OP_OR       = 5'd15;
   localparam operation_type OP_AND      = 5'd16;
   localparam operation_type OP_J        = 5'd17;
   localparam operation_type OP_BEQZ     = 5'd18;
   localparam operation_type OP_BNEZ     = 5'd19;
   localparam operation_type OP_SLLI     = 5'd20;
   localparam operation_type OP_LWSP     = 5'd21;
   localparam operation_type OP_JR       = 5'd22;
   localparam operation_type OP_MV       = 5'd23;
   localparam operation_type OP_EBREAK   = 5'd24;
   localparam operation_type OP_JALR     = 5'd25;
   localparam operation_type OP_ADD      = 5'd26;
   localparam operation_type OP_SWSP     = 5'd27;

   localparam format_type FMT_NONE      = 4'd0;
   localparam format_type FMT_CR        = 4'd1;
   localparam format_type FMT_CI        = 4'd2;
   localparam format_type FMT_CSS       = 4'd3;
   localparam format_type FMT_CIW       = 4'd4;
   localparam format_type FMT_CL        = 4'd5;
   localparam format_type FMT_CS        = 4'd6;
   localparam format_type FMT_CA        = 4'd7;
   localparam format_type FMT_CB_ARITH  = 4'd8;
   localparam format_type FMT_CB_BRANCH = 4'd9;
   localparam format_type FMT_CJ        = 4'd10;

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;

   localparam reg_num_type REG_ZERO = 5'd0;
   localparam reg_num_type REG_RA   = 5'd1;
   localparam reg_num_type REG_SP   = 5'd2;

   localparam logic [1:0] CREG_BASE = 2'b01;

endpackage

/* rtl/core/rv32cd_classify.sv */
module rv32cd_classify (
   input  rv32cd_pkg::halfword_type halfword,
   output rv32cd_pkg::class_type    cls
);

   logic [1:0] quad;
   logic [2:0] f3;
   logic [4:0] r_hi;
   logic [4:0] r_lo;
   logic       b12;
   logic       imm6_nz;

   assign quad    = halfword[1:0];
   assign f3      = halfword[15:13];
   assign r_hi    = halfword[11:7];
   assign r_lo    = halfword[6:2];
   assign b12     = halfword[12];
   assign imm6_nz = (b12 != 1'b0) || (r_lo != 5'd0);

   always_comb begin
      cls.operation = rv32cd_pkg::OP_ILLEGAL;
      cls.format    = rv32cd_pkg::FMT_NONE;
      case (quad)
         rv32cd_pkg::QUAD_0: begin
            case (f3)
               3'd0: begin
                  if (halfword[12:5] != 8'd0) begin
                     cls.operation = rv32cd_pkg::OP_ADDI4SPN;
                     cls.format    = rv32cd_pkg::FMT_CIW;
                  end
               end
               3'd2: begin
                  cls.operation = rv32cd_pkg::OP_LW;
                  cls.format    = rv32cd_pkg::FMT_CL;
               end
               3'd6: begin
                  cls.operation = rv32cd_pkg::OP_SW;
                  cls.format    = rv32cd_pkg::FMT_CS;
               end
               default: ;
            endcase
         end
         rv32cd_pkg::QUAD_1: begin
            case (f3)
               3'd0: begin
                  if (r_hi == 5'd0) begin
                     if (!imm6_nz) begin
                        cls.operation = rv32cd_pkg::OP_NOP;
                        cls.format    = rv32cd_pkg::FMT_CI;
                     end
                  end else if (imm6_nz) begin
                     cls.operation = rv32cd_pkg::OP_ADDI;
                     cls.format    = rv32cd_pkg::FMT_CI;
                  end
               end
               3'd1: begin
                  cls.operation = rv32cd_pkg::OP_JAL;
                  cls.format    = rv32cd_pkg::FMT_CJ;
               end
               3'd5: begin
                  cls.operation = rv32cd_pkg::OP_J;
                  cls.format    = rv32cd_pkg::FMT_CJ;
               end
               3'd2: begin
                  if (r_hi != 5'd0) begin
                     cls.operation = rv32cd_pkg::OP_LI;
                     cls.format    = rv32cd_pkg::FMT_CI;
                  end
               end
               3'd3: begin
                  if (r_hi == rv32cd_pkg::REG_SP) begin
                     if ({b12, halfword[6:2]} != 6'd0) begin
                        cls.operation = rv32cd_pkg::OP_ADDI16SP;
                        cls.format    = rv32cd_pkg::FMT_CI;
                     end
                  end else if (r_hi != 5'd0 && imm6_nz) begin
                     cls.operation = rv32cd_pkg::OP_LUI;
                     cls.format    = rv32cd_pkg::FMT_CI;
                  end
               end
               3'd4: begin
                  case (halfword[11:10])
                     2'd0, 2'd1: begin
                        if (!b12 && r_lo != 5'd0) begin
                           cls.operation = halfword[10] ? rv32cd_pkg::OP_SRAI
                                                        : rv32cd_pkg::OP_SRLI;
                           cls.format    = rv32cd_pkg::FMT_CB_ARITH;
                        end
                     end
                     2'd2: begin
                        cls.operation = rv32cd_pkg::OP_ANDI;
                        cls.format    = rv32cd_pkg::FMT_CB_ARITH;
                     end
                     default: begin
                        if (!b12) begin
                           cls.operation = rv32cd_pkg::OP_SUB
                                           + rv32cd_pkg::operation_type'(halfword[6:5]);
                           cls.format    = rv32cd_pkg::FMT_CA;
                        end
                     end
                  endcase
               end
               3'd6: begin
                  cls.operation = rv32cd_pkg::OP_BEQZ;
                  cls.format    = rv32cd_pkg::FMT_CB_BRANCH;
               end
               default: begin
                  cls.operation = rv32cd_pkg::OP_BNEZ;
                  cls.format    = rv32cd_pkg::FMT_CB_BRANCH;
               end
            endcase
         end
         rv32cd_pkg::QUAD_2: begin
            case (f3)
               3'd0: begin
                  if (!b12 && r_hi != 5'd0 && r_lo != 5'd0) begin
                     cls.operation = rv32cd_pkg::OP_SLLI;
                     cls.format    = rv32cd_pkg::FMT_CI;
                  end
               end
               3'd2: begin
                  if (r_hi != 5'd0) begin
                     cls.operation = rv32cd_pkg::OP_LWSP;
                     cls.format    = rv32cd_pkg::FMT_CI;
                  end
               end
               3'd4: begin
                  if (!b12) begin
                     if (r_hi != 5'd0) begin
                        cls.operation = (r_lo == 5'd0) ? rv32cd_pkg::OP_JR
                                                       : rv32cd_pkg::OP_MV;
                        cls.format    = rv32cd_pkg::FMT_CR;
                     end
                  end else if (r_lo == 5'd0 && r_hi == 5'd0) begin
                     cls.operation = rv32cd_pkg::OP_EBREAK;
                     cls.format    = rv32cd_pkg::FMT_CR;
                  end else if (r_lo == 5'd0) begin
                     cls.operation = rv32cd_pkg::OP_JALR;
                     cls.format    = rv32cd_pkg::FMT_CR;
                  end else if (r_hi != 5'd0) begin
                     cls.operation = rv32cd_pkg::OP_ADD;
                     cls.format    = rv32cd_pkg::FMT_CR;
                  end
               end
               3'd6: begin
                  cls.operation = rv32cd_pkg::OP_SWSP;
                  cls.format    = rv32cd_pkg::FMT_CSS;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

endmodule

/* rtl/core/rv32cd_fields.sv */
module rv32cd_fields (
   input  rv32cd_pkg::halfword_type  halfword,
   input  rv32cd_pkg::operation_type operation,
   output rv32cd_pkg::reg_num_type   dest_reg,
   output rv32cd_pkg::reg_num_type   src_reg_a,
   output rv32cd_pkg::reg_num_type   src_reg_b,
   output rv32cd_pkg::imm_type       immediate
);

   rv32cd_pkg::reg_num_type r_hi;
   rv32cd_pkg::reg_num_type r_lo;
   rv32cd_pkg::reg_num_type p_hi;
   rv32cd_pkg::reg_num_type p_lo;
   logic [17:0] imm6_s;
   logic [17:0] memoff;
   logic [17:0] cj_s;
   logic [17:0] cb_s;

   assign r_hi   = halfword[11:7];
   assign r_lo   = halfword[6:2];
   assign p_hi   = {rv32cd_pkg::CREG_BASE, halfword[9:7]};
   assign p_lo   = {rv32cd_pkg::CREG_BASE, halfword[4:2]};
   assign imm6_s = {{12{halfword[12]}}, halfword[12], halfword[6:2]};
   assign memoff = {11'd0, halfword[5], halfword[12:10], halfword[6], 2'b00};
   assign cj_s   = {{7{halfword[12]}}, halfword[8], halfword[10:9], halfword[6],
                    halfword[7], halfword[2], halfword[11], halfword[5:3], 1'b0};
   assign cb_s   = {{10{halfword[12]}}, halfword[6:5], halfword[2], halfword[11:10],
                    halfword[4:3], 1'b0};

   always_comb begin
      logic [17:0] imm;
      imm       = '0;
      dest_reg  = rv32cd_pkg::REG_ZERO;
      src_reg_a = rv32cd_pkg::REG_ZERO;
      src_reg_b = rv32cd_pkg::REG_ZERO;
      case (operation)
         rv32cd_pkg::OP_ADDI4SPN: begin
            dest_reg  = p_lo;
            src_reg_a = rv32cd_pkg::REG_SP;
            imm = {8'd0, halfword[10:7], halfword[12:11], halfword[5], halfword[6], 2'b00};
         end
         rv32cd_pkg::OP_LW: begin
            dest_reg  = p_lo;
            src_reg_a = p_hi;
            imm       = memoff;
         end
         rv32cd_pkg::OP_SW: begin
            src_reg_a = p_hi;
            src_reg_b = p_lo;
            imm       = memoff;
         end
         rv32cd_pkg::OP_ADDI: begin
            dest_reg  = r_hi;
            src_reg_a = r_hi;
            imm       = imm6_s;
         end
         rv32cd_pkg::OP_JAL: begin
            dest_reg = rv32cd_pkg::REG_RA;
            imm      = cj_s;
         end
         rv32cd_pkg::OP_J: begin
            imm = cj_s;
         end
         rv32cd_pkg::OP_LI: begin
            dest_reg = r_hi;
            imm      = imm6_s;
         end
         rv32cd_pkg::OP_ADDI16SP: begin
            dest_reg  = rv32cd_pkg::REG_SP;
            src_reg_a = rv32cd_pkg::REG_SP;
            imm = {{9{halfword[12]}}, halfword[4:3], halfword[5], halfword[2],
                   halfword[6], 4'd0};
         end
         rv32cd_pkg::OP_LUI: begin
            dest_reg = r_hi;
            imm      = {halfword[12], halfword[6:2], 12'd0};
         end
         rv32cd_pkg::OP_SRLI, rv32cd_pkg::OP_SRAI: begin
            dest_reg  = p_hi;
            src_reg_a = p_hi;
            imm       = {13'd0, r_lo};
         end
         rv32cd_pkg::OP_ANDI: begin
            dest_reg  = p_hi;
            src_reg_a = p_hi;
            imm       = imm6_s;
         end
         rv32cd_pkg::OP_SUB, rv32cd_pkg::OP_XOR, rv32cd_pkg::OP_OR,
         rv32cd_pkg::OP_AND: begin
            dest_reg  = p_hi;
            src_reg_a = p_hi;
            src_reg_b = p_lo;
         end
         rv32cd_pkg::OP_BEQZ, rv32cd_pkg::OP_BNEZ: begin
            src_reg_a = p_hi;
            imm       = cb_s;
         end
         rv32cd_pkg::OP_SLLI: begin
            dest_reg  = r_hi;
            src_reg_a = r_hi;
            imm       = {13'd0, r_lo};
         end
         rv32cd_pkg::OP_LWSP: begin
            dest_reg  = r_hi;
            src_reg_a = rv32cd_pkg::REG_SP;
            imm = {10'd0, halfword[3:2], halfword[12], halfword[6:4], 2'b00};
         end
         rv32cd_pkg::OP_JR: begin
            src_reg_a = r_hi;
         end
         rv32cd_pkg::OP_MV: begin
            dest_reg  = r_hi;
            src_reg_b = r_lo;
         end
         rv32cd_pkg::OP_JALR: begin
            dest_reg  = rv32cd_pkg::REG_RA;
            src_reg_a = r_hi;
         end
         rv32cd_pkg::OP_ADD: begin
            dest_reg  = r_hi;
            src_reg_a = r_hi;
            src_reg_b = r_lo;
         end
         rv32cd_pkg::OP_SWSP: begin
            src_reg_a = rv32cd_pkg::REG_SP;
            src_reg_b = r_lo;
            imm       = {10'd0, halfword[8:7], halfword[12:9], 2'b00};
         end
         default: ;
      endcase
      immediate = rv32cd_pkg::imm_type'(imm);
   end

endmodule

/* rtl/core/rv32c_instruction_decoder_core.sv */
// channel   ports                                   direction
// req       req_valid, req_stall, req_halfword      word in
// rsp       rsp_valid, rsp_stall, rsp_operation,    word out
//           rsp_format, rsp_dest_reg, rsp_src_reg_a,
//           rsp_src_reg_b, rsp_immediate
//
// three register stages: input word, operation/format, register and immediate fields
// one word per cycle without rsp_stall; rsp_valid rises when the word reaches s3
// synchronous reset clears the stage valid bits only
// rsp_stall holds the output stage; a stage still advances into an empty one ahead
module rv32c_instruction_decoder_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  rv32cd_pkg::halfword_type      req_halfword,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output rv32cd_pkg::operation_type     rsp_operation,
   output rv32cd_pkg::format_type        rsp_format,
   output rv32cd_pkg::reg_num_type       rsp_dest_reg,
   output rv32cd_pkg::reg_num_type       rsp_src_reg_a,
   output rv32cd_pkg::reg_num_type       rsp_src_reg_b,
   output rv32cd_pkg::imm_type           rsp_immediate
);

   logic                      s1_valid_ff;
   rv32cd_pkg::halfword_type  s1_word_ff;
   logic                      s2_valid_ff;
   rv32cd_pkg::halfword_type  s2_word_ff;
   rv32cd_pkg::class_type     s2_class_ff;
   rv32cd_pkg::class_type     s2_class_in;
   logic                      s3_valid_ff;
   rv32cd_pkg::class_type     s3_class_ff;
   rv32cd_pkg::reg_num_type   s3_dest_ff;
   rv32cd_pkg::reg_num_type   s3_src_a_ff;
   rv32cd_pkg::reg_num_type   s3_src_b_ff;
   rv32cd_pkg::imm_type       s3_imm_ff;
   rv32cd_pkg::reg_num_type   s3_dest_in;
   rv32cd_pkg::reg_num_type   s3_src_a_in;
   rv32cd_pkg::reg_num_type   s3_src_b_in;
   rv32cd_pkg::imm_type       s3_imm_in;
   logic                      adv1;
   logic                      adv2;
   logic                      adv3;

   assign adv3 = !s3_valid_ff || !rsp_stall;
   assign adv2 = !s2_valid_ff || adv3;
   assign adv1 = !s1_valid_ff || adv2;
   assign req_stall = !adv1;

   rv32cd_classify u_classify (
      .halfword (s1_word_ff),
      .cls      (s2_class_in)
   );

   rv32cd_fields u_fields (
      .halfword  (s2_word_ff),
      .operation (s2_class_ff.operation),
      .dest_reg  (s3_dest_in),
      .src_reg_a (s3_src_a_in),
      .src_reg_b (s3_src_b_in),
      .immediate (s3_imm_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (adv1) begin
            s1_valid_ff <= req_valid;
         end
         if (adv2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (adv3) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv1 && req_valid) begin
         s1_word_ff <= req_halfword;
      end
      if (adv2 && s1_valid_ff) begin
         s2_word_ff  <= s1_word_ff;
         s2_class_ff <= s2_class_in;
      end
      if (adv3 && s2_valid_ff) begin
         s3_class_ff <= s2_class_ff;
         s3_dest_ff  <= s3_dest_in;
         s3_src_a_ff <= s3_src_a_in;
         s3_src_b_ff <= s3_src_b_in;
         s3_imm_ff   <= s3_imm_in;
      end
   end

   assign rsp_valid     = s3_valid_ff;
   assign rsp_operation = s3_class_ff.operation;
   assign rsp_format    = s3_class_ff.format;
   assign rsp_dest_reg  = s3_dest_ff;
   assign rsp_src_reg_a = s3_src_a_ff;
   assign rsp_src_reg_b = s3_src_b_ff;
   assign rsp_immediate = s3_imm_ff;

endmodule
